/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent, with a message.
`define ASSERT_AFTER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ptl_pkg.sv */
`default_nettype none

package ptl_pkg;

  // Light phases, in the order the controller walks through them.
  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_GREEN  = 2'd1,
    PH_BLINK  = 2'd2,
    PH_YELLOW = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_FULL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW     = 3'd4;

  // Register values after reset, in ticks.
  localparam logic [CFG_W-1:0] RST_RED_FULL   = 16'd4000;
  localparam logic [CFG_W-1:0] RST_GREEN      = 16'd1000;
  localparam logic [CFG_W-1:0] RST_BLINK      = 16'd1000;
  localparam logic [CFG_W-1:0] RST_BLINK_HALF = 16'd250;
  localparam logic [CFG_W-1:0] RST_YELLOW     = 16'd1000;

  // One result beat: lamp drives and the phase after the tick.
  typedef struct packed {
    logic   red_lamp;
    logic   yellow_lamp;
    logic   green_lamp;
    phase_t light_phase;
  } result_t;

endpackage

`default_nettype wire

/* src/pedestrian_traffic_light_fsm_top.sv */
`default_nettype none

// Pedestrian traffic light controller. Each input beat is one millisecond tick
// with a pedestrian press flag; each tick yields exactly one result beat with
// the red, yellow and green lamp drives and the phase after that tick. The
// phases run red, steady green, blinking green and yellow, each for the number
// of ticks held in its configuration register. A press late in red ends red at
// once; any other press shortens the next red to a quarter of its full length.
// The phase state registers update on the edge that accepts a beat, and the result
// lands in the output register (or in the skid register while the output register
// is held), so a new tick is accepted every cycle while in_stall is low. A two-entry
// output buffer (output register plus skid register) lets the block accept one more
// tick while the consumer stalls; in_stall rises only when both entries are full.
module pedestrian_traffic_light_fsm_top
  import ptl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // Configuration write port
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_wdata,
  // Tick input channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_button_press,
  // Result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_red_lamp,
  output logic                 out_yellow_lamp,
  output logic                 out_green_lamp,
  output logic [1:0]           out_light_phase
);

`include "assert_macros.svh"

  // Compares run at the wider of the counter and register widths.
  localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  // Configuration registers.
  logic [CFG_W-1:0] red_full_r, green_r, blink_r, blink_half_r, yellow_r;

  // Phase state.
  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] phase_ticks_r, phase_ticks_nxt;
  logic [TIMER_WIDTH-1:0] toggle_ticks_r, toggle_ticks_nxt;
  logic                   red_is_short_r, red_is_short_nxt;
  logic                   shorten_next_r, shorten_next_nxt;
  logic                   blink_on_r, blink_on_nxt;

  // Output buffer.
  logic    out_valid_r, skid_valid_r;
  result_t out_res_r, skid_res_r, res_nxt;

  logic in_accept, out_take;

  // Comparison operands.
  logic [CMP_W-1:0]       ticks_c, toggle_c, quarter_c, red_lim_c;
  logic [TIMER_WIDTH-1:0] ticks_inc, toggle_inc;
  logic                   early_exit;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_full_r   <= RST_RED_FULL;
      green_r      <= RST_GREEN;
      blink_r      <= RST_BLINK;
      blink_half_r <= RST_BLINK_HALF;
      yellow_r     <= RST_YELLOW;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RED_FULL:   red_full_r   <= cfg_wdata;
        CFG_GREEN:      green_r      <= cfg_wdata;
        CFG_BLINK:      blink_r      <= cfg_wdata;
        CFG_BLINK_HALF: blink_half_r <= cfg_wdata;
        CFG_YELLOW:     yellow_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturating tick counters.
  assign ticks_inc  = (&phase_ticks_r) ? phase_ticks_r : phase_ticks_r + 1'b1;
  assign toggle_inc = (&toggle_ticks_r) ? toggle_ticks_r : toggle_ticks_r + 1'b1;
  assign ticks_c    = CMP_W'(ticks_inc);
  assign toggle_c   = CMP_W'(toggle_inc);
  assign quarter_c  = CMP_W'(red_full_r >> 2);
  assign red_lim_c  = red_is_short_r ? quarter_c : CMP_W'(red_full_r);

  // A press once the short red time has passed ends red at once.
  assign early_exit = in_button_press && (phase_r == PH_RED) && (ticks_c > quarter_c);

  // Next phase state for one tick.
  always_comb begin
    phase_nxt        = phase_r;
    phase_ticks_nxt  = ticks_inc;
    toggle_ticks_nxt = toggle_ticks_r;
    red_is_short_nxt = red_is_short_r;
    shorten_next_nxt = shorten_next_r;
    blink_on_nxt     = blink_on_r;

    if (in_button_press) begin
      shorten_next_nxt = !early_exit;
    end

    if (early_exit) begin
      phase_nxt       = PH_GREEN;
      phase_ticks_nxt = '0;
    end else begin
      case (phase_r)
        PH_RED: begin
          if (ticks_c >= red_lim_c) begin
            phase_nxt       = PH_GREEN;
            phase_ticks_nxt = '0;
          end
        end
        PH_GREEN: begin
          if (ticks_c >= CMP_W'(green_r)) begin
            phase_nxt        = PH_BLINK;
            phase_ticks_nxt  = '0;
            blink_on_nxt     = 1'b0;
            toggle_ticks_nxt = '0;
          end
        end
        PH_BLINK: begin
          toggle_ticks_nxt = toggle_inc;
          if (toggle_c >= CMP_W'(blink_half_r)) begin
            toggle_ticks_nxt = '0;
            blink_on_nxt     = !blink_on_r;
          end
          if (ticks_c >= CMP_W'(blink_r)) begin
            phase_nxt       = PH_YELLOW;
            phase_ticks_nxt = '0;
          end
        end
        PH_YELLOW: begin
          if (ticks_c >= CMP_W'(yellow_r)) begin
            phase_nxt        = PH_RED;
            phase_ticks_nxt  = '0;
            red_is_short_nxt = shorten_next_nxt;
            shorten_next_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Lamp drives follow the phase after this tick.
    res_nxt.red_lamp    = (phase_nxt == PH_RED);
    res_nxt.yellow_lamp = (phase_nxt == PH_YELLOW);
    res_nxt.green_lamp  = (phase_nxt == PH_GREEN) ||
                          ((phase_nxt == PH_BLINK) && blink_on_nxt);
    res_nxt.light_phase = phase_nxt;
  end

  // Phase state registers advance on each accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_RED;
      phase_ticks_r  <= '0;
      toggle_ticks_r <= '0;
      red_is_short_r <= 1'b0;
      shorten_next_r <= 1'b0;
      blink_on_r     <= 1'b0;
    end else if (in_accept) begin
      phase_r        <= phase_nxt;
      phase_ticks_r  <= phase_ticks_nxt;
      toggle_ticks_r <= toggle_ticks_nxt;
      red_is_short_r <= red_is_short_nxt;
      shorten_next_r <= shorten_next_nxt;
      blink_on_r     <= blink_on_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_res_r    <= skid_res_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_res_r   <= res_nxt;
        skid_valid_r <= 1'b1;
      end else begin
        out_res_r   <= res_nxt;
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_lamp    = out_res_r.red_lamp;
  assign out_yellow_lamp = out_res_r.yellow_lamp;
  assign out_green_lamp  = out_res_r.green_lamp;
  assign out_light_phase = out_res_r.light_phase;

  // The skid entry only fills behind a full output register.
  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r,
                 "skid entry valid while output register is empty")

  // Without a tick the phase and its counter hold.
  `ASSERT_AFTER(a_state_holds, !in_accept,
                $stable(phase_r) && $stable(phase_ticks_r),
                "phase state changed without an accepted tick")

  // Red and yellow lamps match the reported phase.
  `ASSERT_SAME(a_lamps_match, out_valid_r,
               (out_red_lamp == (out_light_phase == PH_RED)) &&
               (out_yellow_lamp == (out_light_phase == PH_YELLOW)),
               "lamp drive disagrees with reported phase")

  // Green is never lit in red or yellow.
  `ASSERT_SAME(a_green_phase, out_valid_r && out_green_lamp,
               (out_light_phase == PH_GREEN) || (out_light_phase == PH_BLINK),
               "green lamp lit outside a green phase")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  import ptl_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int ROUND_TICKS  = 130;
  localparam int ROUNDS       = 7;
  localparam int HOLD_CYCLES  = 240;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_button_press;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_red_lamp;
  logic                 out_yellow_lamp;
  logic                 out_green_lamp;
  logic [1:0]           out_light_phase;

  pedestrian_traffic_light_fsm_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_press (in_button_press),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_lamp    (out_red_lamp),
    .out_yellow_lamp (out_yellow_lamp),
    .out_green_lamp  (out_green_lamp),
    .out_light_phase (out_light_phase)
  );

  // Mirror of the timing registers.
  logic [CFG_W-1:0] red_full_len = RST_RED_FULL;
  logic [CFG_W-1:0] green_len = RST_GREEN;
  logic [CFG_W-1:0] blink_len = RST_BLINK;
  logic [CFG_W-1:0] blink_half_len = RST_BLINK_HALF;
  logic [CFG_W-1:0] yellow_len = RST_YELLOW;

  // Predicted controller state.
  phase_t     lt_phase = PH_RED;
  logic [15:0] lt_ticks = '0;
  logic [15:0] lt_toggle_ticks = '0;
  bit         lt_red_short = 1'b0;
  bit         lt_shorten_next = 1'b0;
  bit         lt_blink_on = 1'b0;

  result_t expected_lamps[$];

  int  mismatches = 0;
  int  beats_checked = 0;
  int  ticks_sent = 0;
  int  settings_used = 0;
  int  cycles = 0;
  bit  idling = 1'b0;
  int  hold_cycles_req = 0;

  // Clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Saturating 16-bit increment, as the tick counters behave.
  function automatic logic [15:0] sat_step(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advances the predicted controller by one tick and returns the lamp drives after it.
  function automatic result_t advance_light(input bit press);
    logic [15:0] quarter;
    bit          early;
    result_t     lamps;
    quarter = red_full_len >> 2;
    early = 1'b0;
    lt_ticks = sat_step(lt_ticks);

    // A late press in red ends red right away; any other press shortens the next red.
    if (press) begin
      if (lt_phase == PH_RED && lt_ticks > quarter) begin
        lt_shorten_next = 1'b0;
        lt_phase = PH_GREEN;
        lt_ticks = '0;
        early = 1'b1;
      end else begin
        lt_shorten_next = 1'b1;
      end
    end

    if (!early) begin
      case (lt_phase)
        PH_RED: begin
          if (lt_ticks >= (lt_red_short ? quarter : red_full_len)) begin
            lt_phase = PH_GREEN;
            lt_ticks = '0;
          end
        end
        PH_GREEN: begin
          if (lt_ticks >= green_len) begin
            lt_phase = PH_BLINK;
            lt_ticks = '0;
            lt_blink_on = 1'b0;
            lt_toggle_ticks = '0;
          end
        end
        PH_BLINK: begin
          lt_toggle_ticks = sat_step(lt_toggle_ticks);
          if (lt_toggle_ticks >= blink_half_len) begin
            lt_toggle_ticks = '0;
            lt_blink_on = !lt_blink_on;
          end
          if (lt_ticks >= blink_len) begin
            lt_phase = PH_YELLOW;
            lt_ticks = '0;
          end
        end
        default: begin
          if (lt_ticks >= yellow_len) begin
            lt_phase = PH_RED;
            lt_ticks = '0;
            lt_red_short = lt_shorten_next;
            lt_shorten_next = 1'b0;
          end
        end
      endcase
    end

    lamps.red_lamp = (lt_phase == PH_RED);
    lamps.yellow_lamp = (lt_phase == PH_YELLOW);
    lamps.green_lamp = (lt_phase == PH_GREEN) || (lt_phase == PH_BLINK && lt_blink_on);
    lamps.light_phase = lt_phase;
    return lamps;
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random phase length: mostly short, sometimes zero or at full scale.
  function automatic logic [CFG_W-1:0] pick_length(input int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 8) return 16'hFFFF;
    if (r < 85) return CFG_W'($urandom_range(1, 8));
    return CFG_W'($urandom_range(9, top));
  endfunction

  // Sends one tick beat and records the lamps it should produce.
  task automatic send_tick(input bit press);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_press <= press;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_lamps.push_back(advance_light(press));
    ticks_sent++;
  endtask

  // Writes one timing register; indexes past the list are dropped by the block.
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RED_FULL:   red_full_len = val;
      CFG_GREEN:      green_len = val;
      CFG_BLINK:      blink_len = val;
      CFG_BLINK_HALF: blink_half_len = val;
      CFG_YELLOW:     yellow_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_all(input logic [CFG_W-1:0] red_full, input logic [CFG_W-1:0] green,
                             input logic [CFG_W-1:0] blink, input logic [CFG_W-1:0] half,
                             input logic [CFG_W-1:0] yellow);
    program_register(CFG_RED_FULL, red_full);
    program_register(CFG_GREEN, green);
    program_register(CFG_BLINK, blink);
    program_register(CFG_BLINK_HALF, half);
    program_register(CFG_YELLOW, yellow);
    settings_used++;
  endtask

  // Waits until every expected beat has come out, then a little longer.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_lamps.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Result stall: random short stalls, a few long ones, and a long hold on request.
  initial begin : out_stall_gen
    int pick;
    int len;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req > 0) begin
        len = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling) begin
        pick = $urandom_range(0, 99);
        if (pick >= 75) begin
          len = (pick >= 97) ? $urandom_range(15, 60) : $urandom_range(1, 3);
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_lamps
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lamps.size() == 0) begin
        $error("result beat with no tick pending");
        mismatches++;
      end else begin
        want = expected_lamps.pop_front();
        if (out_red_lamp !== want.red_lamp) begin
          $error("red_lamp: expected %0d, got %0d", want.red_lamp, out_red_lamp);
          mismatches++;
        end
        if (out_yellow_lamp !== want.yellow_lamp) begin
          $error("yellow_lamp: expected %0d, got %0d", want.yellow_lamp, out_yellow_lamp);
          mismatches++;
        end
        if (out_green_lamp !== want.green_lamp) begin
          $error("green_lamp: expected %0d, got %0d", want.green_lamp, out_green_lamp);
          mismatches++;
        end
        if (out_light_phase !== want.light_phase) begin
          $error("light_phase: expected %0d, got %0d", want.light_phase, out_light_phase);
          mismatches++;
        end
        beats_checked++;
      end
    end
  end

  // A few ticks with the values the registers come up with.
  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
  endtask

  // Zero lengths end every phase at once; a zero half period toggles every tick.
  task automatic test_zero_lengths();
    program_all('0, '0, '0, '0, '0);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
    program_register(CFG_RED_FULL, 16'd3);
    repeat (3) send_tick(1'b1);
    settle();
  endtask

  // Presses placed at chosen points: early in red, late in red, in green and
  // in the last tick of yellow.
  task automatic test_press_handling();
    bit press;
    program_all(16'd8, 16'd3, 16'd4, 16'd1, 16'd2);
    repeat (16) begin
      press = (lt_phase == PH_RED && lt_ticks == 16'd0 && !lt_red_short)
           || (lt_phase == PH_RED && lt_ticks == 16'd3)
           || (lt_phase == PH_GREEN && lt_ticks == 16'd1)
           || (lt_phase == PH_YELLOW && lt_ticks + 16'd1 == yellow_len);
      send_tick(press);
    end
    settle();
  endtask

  // Writes to indexes past the register list must change nothing.
  task automatic test_unused_indexes();
    program_register(3'd5, 16'hFFFF);
    program_register(3'd6, 16'h0000);
    program_register(3'd7, 16'hA5A5);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  // Output held off for a long stretch while ticks keep coming, so the input stalls.
  task automatic test_input_backpressure();
    idling = 1'b0;
    program_all(16'd6, 16'd3, 16'd5, 16'd2, 16'd2);
    hold_cycles_req = HOLD_CYCLES;
    repeat (40) send_tick($urandom_range(0, 9) == 0);
    settle();
  endtask

  // Random press traffic over several random register settings.
  task automatic test_random_traffic();
    int press_pct;
    for (int round = 0; round < ROUNDS; round++) begin
      idling = (round % 3 != 2);
      program_all(pick_length(48), pick_length(20), pick_length(20),
                  pick_length(8), pick_length(20));
      case (round % 4)
        0: press_pct = 3;
        1: press_pct = 12;
        2: press_pct = 35;
        default: press_pct = 70;
      endcase
      repeat (ROUND_TICKS) send_tick($urandom_range(0, 99) < press_pct);
      settle();
    end
  endtask

  // A fresh full red at the largest length holds through a run of ticks with no presses.
  task automatic test_longest_red();
    idling = 1'b0;
    program_all(16'd2, 16'd2, 16'd2, 16'd1, 16'd2);
    while (!(lt_phase == PH_RED && lt_ticks == 16'd0 && !lt_red_short)) send_tick(1'b0);
    settle();
    program_register(CFG_RED_FULL, 16'hFFFF);
    settings_used++;
    repeat (60) send_tick(1'b0);
    settle();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_button_press <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_lengths();
    test_press_handling();
    test_unused_indexes();
    test_input_backpressure();
    test_random_traffic();
    test_longest_red();

    repeat (5) @(posedge clk);
    $display("Checked %0d lamp beats from %0d ticks over %0d register settings.",
             beats_checked, ticks_sent, settings_used);
    $display("Covered zero lengths, unused indexes, a long output hold and a maximum-length red.");
    if (mismatches == 0 && expected_lamps.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
